// ===== rtl/vdps_pkg.sv =====
// shared types, constants and register map of the vector display point scanner
// no dependencies; imported by every module of the block
package vdps_pkg;

    // default values of the top-level parameters
    localparam int DEF_POINT_DEPTH = 1024;
    localparam int DEF_DAC_BITS    = 12;

    // field widths
    localparam int IDX_W    = 10;   // load_index and scan index
    localparam int COORD_W  = 8;    // point_x, point_y
    localparam int OFS_W    = 12;   // offset and span registers
    localparam int DIV_W    = 9;    // divisor registers
    localparam int CNT_W    = 11;   // point_count register
    localparam int SCALE_W  = 12;   // scaled coordinate inside a DAC word
    localparam int XWORD_W  = 13;
    localparam int YWORD_W  = 16;
    localparam int MAG_W    = 20;   // magnitude of coordinate times span difference
    localparam int PROD_W   = COORD_W + 1 + OFS_W + 1;  // signed product
    localparam int SUM_W    = 22;   // offset plus signed quotient
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // DAC word headers
    localparam logic [0:0] X_HDR = 1'b1;
    localparam logic [3:0] Y_HDR = 4'h9;

    // operation codes carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes (byte address is four times the index)
    localparam logic [2:0] REG_X_OFFSET_MIN = 3'd0;
    localparam logic [2:0] REG_X_SPAN_MAX   = 3'd1;
    localparam logic [2:0] REG_X_DIVISOR    = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET_MIN = 3'd3;
    localparam logic [2:0] REG_Y_SPAN_MAX   = 3'd4;
    localparam logic [2:0] REG_Y_DIVISOR    = 3'd5;
    localparam logic [2:0] REG_POINT_COUNT  = 3'd6;

    // configuration register set
    typedef struct packed {
        logic [OFS_W-1:0] x_offset_min;
        logic [OFS_W-1:0] x_span_max;
        logic [DIV_W-1:0] x_divisor;
        logic [OFS_W-1:0] y_offset_min;
        logic [OFS_W-1:0] y_span_max;
        logic [DIV_W-1:0] y_divisor;
        logic [CNT_W-1:0] point_count;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;       // store a loaded point
        logic rd_en;       // read the point at the scan index
        logic mul_en;      // form both products
        logic div_start;   // launch both dividers
        logic out_load;    // capture the result and advance the scan index
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/vdps_div.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on vdps_pkg for operand widths
module vdps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vdps_pkg::MAG_W-1:0] i_dividend,
    input  logic [vdps_pkg::DIV_W-1:0] i_divisor,
    output logic [vdps_pkg::MAG_W-1:0] o_quotient,
    output logic                       o_done
);
    import vdps_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    // one shift-subtract step
    always_comb begin
        trial = {r_rem, r_quo[MAG_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_quo = {r_quo[MAG_W-2:0], fits};
    end

    // control: step count, busy and done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(MAG_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/vdps_dp.sv =====
// datapath: point memory, scan index, products, dividers, clamp and result register
// depends on vdps_pkg and vdps_div
module vdps_dp #(
    parameter int POINT_DEPTH = vdps_pkg::DEF_POINT_DEPTH,
    parameter int DAC_BITS    = vdps_pkg::DEF_DAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vdps_pkg::t_cfg                i_cfg,
    input  vdps_pkg::t_dp_cmd             i_cmd,
    output vdps_pkg::t_dp_stat            o_stat,
    input  logic [vdps_pkg::IDX_W-1:0]    i_load_index,
    input  logic [vdps_pkg::COORD_W-1:0]  i_point_x,
    input  logic [vdps_pkg::COORD_W-1:0]  i_point_y,
    input  logic                          i_point_blank,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [vdps_pkg::M_DATA_W-1:0] o_m_tdata
);
    import vdps_pkg::*;

    localparam int MEM_DEPTH = (POINT_DEPTH < (1 << IDX_W)) ? POINT_DEPTH : (1 << IDX_W);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int ENT_W     = 2 * COORD_W + 1;
    localparam logic signed [SUM_W-1:0] DAC_TOP = SUM_W'((1 << DAC_BITS) - 1);

    // point memory, entry = {blank, y, x}
    logic [ENT_W-1:0] mem [MEM_DEPTH];
    logic [ENT_W-1:0] r_rd_data;
    logic             ld_ok;
    logic [AW-1:0]    rd_addr;

    logic [IDX_W-1:0] r_scan, n_scan;
    logic [IDX_W:0]   scan_inc;

    logic signed [OFS_W:0]    x_diff, y_diff;
    logic signed [PROD_W-1:0] r_x_prod, r_y_prod;
    logic [PROD_W-1:0]        x_abs, y_abs;
    logic                     r_x_neg, r_y_neg;
    logic [DIV_W-1:0]         x_dvs, y_dvs;
    logic [MAG_W-1:0]         x_quo, y_quo;
    logic                     x_done, y_done;

    logic [SUM_W-1:0]        x_qext, y_qext;
    logic signed [SUM_W-1:0] x_sum, y_sum;
    logic [SCALE_W:0]        x_cl, y_cl;

    logic                r_out_vld;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    // saturate into the DAC range, msb flags a clip
    function automatic logic [SCALE_W:0] clamp_coord(input logic signed [SUM_W-1:0] v);
        logic [SCALE_W:0] res;
        if (v < 0) begin
            res = {1'b1, {SCALE_W{1'b0}}};
        end else if (v > DAC_TOP) begin
            res = {1'b1, DAC_TOP[SCALE_W-1:0]};
        end else begin
            res = {1'b0, v[SCALE_W-1:0]};
        end
        return res;
    endfunction

    // memory write on load, registered read on tick
    assign ld_ok   = ({{(32-IDX_W){1'b0}}, i_load_index} < 32'(POINT_DEPTH));
    assign rd_addr = ({{(32-IDX_W){1'b0}}, r_scan} < 32'(MEM_DEPTH)) ? r_scan[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && ld_ok) begin
            mem[i_load_index[AW-1:0]] <= {i_point_blank, i_point_y, i_point_x};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // scan index advance with wrap at point_count and at the depth
    always_comb begin
        scan_inc = {1'b0, r_scan} + 1'b1;
        if ((scan_inc >= i_cfg.point_count) ||
            ({{(31-IDX_W){1'b0}}, scan_inc} >= 32'(POINT_DEPTH))) begin
            n_scan = '0;
        end else begin
            n_scan = scan_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.out_load) begin
            r_scan <= n_scan;
        end
    end

    // coordinate times span difference
    assign x_diff = $signed({1'b0, i_cfg.x_span_max}) - $signed({1'b0, i_cfg.x_offset_min});
    assign y_diff = $signed({1'b0, i_cfg.y_span_max}) - $signed({1'b0, i_cfg.y_offset_min});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_x_prod <= PROD_W'($signed({1'b0, r_rd_data[COORD_W-1:0]})) *
                        PROD_W'(x_diff);
            r_y_prod <= PROD_W'($signed({1'b0, r_rd_data[2*COORD_W-1:COORD_W]})) *
                        PROD_W'(y_diff);
        end
    end

    // divider operands: magnitude, sign kept aside, zero divisor acts as one
    assign x_abs = r_x_prod[PROD_W-1] ? PROD_W'(-r_x_prod) : PROD_W'(r_x_prod);
    assign y_abs = r_y_prod[PROD_W-1] ? PROD_W'(-r_y_prod) : PROD_W'(r_y_prod);
    assign x_dvs = (i_cfg.x_divisor == '0) ? DIV_W'(1) : i_cfg.x_divisor;
    assign y_dvs = (i_cfg.y_divisor == '0) ? DIV_W'(1) : i_cfg.y_divisor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_x_neg <= r_x_prod[PROD_W-1];
            r_y_neg <= r_y_prod[PROD_W-1];
        end
    end

    vdps_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (x_abs[MAG_W-1:0]),
        .i_divisor  (x_dvs),
        .o_quotient (x_quo),
        .o_done     (x_done)
    );

    vdps_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (y_abs[MAG_W-1:0]),
        .i_divisor  (y_dvs),
        .o_quotient (y_quo),
        .o_done     (y_done)
    );

    // signed quotient plus offset, clamp and pack
    always_comb begin
        x_qext = {{(SUM_W-MAG_W){1'b0}}, x_quo};
        y_qext = {{(SUM_W-MAG_W){1'b0}}, y_quo};
        x_sum  = $signed({{(SUM_W-OFS_W){1'b0}}, i_cfg.x_offset_min}) +
                 $signed(r_x_neg ? (~x_qext + 1'b1) : x_qext);
        y_sum  = $signed({{(SUM_W-OFS_W){1'b0}}, i_cfg.y_offset_min}) +
                 $signed(r_y_neg ? (~y_qext + 1'b1) : y_qext);
        x_cl   = clamp_coord(x_sum);
        y_cl   = clamp_coord(y_sum);
        n_out_data = {1'b0,
                      x_cl[SCALE_W] | y_cl[SCALE_W],
                      Y_HDR, y_cl[SCALE_W-1:0],
                      X_HDR, x_cl[SCALE_W-1:0],
                      ~r_rd_data[ENT_W-1]};
    end

    // result register toward the master side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_stat.div_done = x_done & y_done;
    assign o_stat.out_free = ~r_out_vld | i_m_tready;
    assign o_m_tvalid      = r_out_vld;
    assign o_m_tdata       = r_out_data;

endmodule

// ===== rtl/vdps_ctrl.sv =====
// controller state machine sequencing load and tick items through the datapath
// depends on vdps_pkg for command and status types
module vdps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_op,
    input  vdps_pkg::t_dp_stat i_stat,
    output logic               o_s_tready,
    output vdps_pkg::t_dp_cmd  o_cmd
);
    import vdps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   xfer;

    assign xfer = i_s_tvalid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.wr_en      = xfer && (i_op == OP_LOAD);
        o_cmd.rd_en      = xfer && (i_op == OP_TICK);
        unique case (r_state)
            S_IDLE: begin
                if (xfer && (i_op == OP_TICK)) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// ===== rtl/vector_display_point_scanner.sv =====
// vector display point scanner: loads are taken back to back while the controller is idle
// a tick reads its point, forms both products, runs the two 20-step dividers, one per
// coordinate, and waits for a free output register; the next item is taken once it is loaded
// a result waits in the output register while the next item is taken
// reset (synchronous, active low) restores register defaults and scan index zero;
// the point memory is not cleared and holds undefined data until loaded
module vector_display_point_scanner #(
    parameter int POINT_DEPTH = vdps_pkg::DEF_POINT_DEPTH,
    parameter int DAC_BITS    = vdps_pkg::DEF_DAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: load_index[9:0], point_x[17:10], point_y[25:18], point_blank[26], zero above
    input  logic [vdps_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: operation
    input  logic                          i_s_tuser,
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: blank_level[0], x_dac_word[13:1], y_dac_word[29:14], clamped[30], zero[31]
    output logic [vdps_pkg::M_DATA_W-1:0] o_m_tdata,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vdps_pkg::PADDR_W-1:0]  paddr,
    input  logic [vdps_pkg::PDATA_W-1:0]  pwdata,
    output logic [vdps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import vdps_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_wr;
    logic [2:0] reg_idx;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset_min <= OFS_W'(0);
            r_cfg.x_span_max   <= OFS_W'(4095);
            r_cfg.x_divisor    <= DIV_W'(255);
            r_cfg.y_offset_min <= OFS_W'(0);
            r_cfg.y_span_max   <= OFS_W'(4095);
            r_cfg.y_divisor    <= DIV_W'(255);
            r_cfg.point_count  <= CNT_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_X_OFFSET_MIN: r_cfg.x_offset_min <= pwdata[OFS_W-1:0];
                REG_X_SPAN_MAX:   r_cfg.x_span_max   <= pwdata[OFS_W-1:0];
                REG_X_DIVISOR:    r_cfg.x_divisor    <= pwdata[DIV_W-1:0];
                REG_Y_OFFSET_MIN: r_cfg.y_offset_min <= pwdata[OFS_W-1:0];
                REG_Y_SPAN_MAX:   r_cfg.y_span_max   <= pwdata[OFS_W-1:0];
                REG_Y_DIVISOR:    r_cfg.y_divisor    <= pwdata[DIV_W-1:0];
                REG_POINT_COUNT:  r_cfg.point_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_X_OFFSET_MIN: prdata = PDATA_W'(r_cfg.x_offset_min);
            REG_X_SPAN_MAX:   prdata = PDATA_W'(r_cfg.x_span_max);
            REG_X_DIVISOR:    prdata = PDATA_W'(r_cfg.x_divisor);
            REG_Y_OFFSET_MIN: prdata = PDATA_W'(r_cfg.y_offset_min);
            REG_Y_SPAN_MAX:   prdata = PDATA_W'(r_cfg.y_span_max);
            REG_Y_DIVISOR:    prdata = PDATA_W'(r_cfg.y_divisor);
            REG_POINT_COUNT:  prdata = PDATA_W'(r_cfg.point_count);
            default:          prdata = '0;
        endcase
    end

    // sequencer
    vdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath
    vdps_dp #(
        .POINT_DEPTH (POINT_DEPTH),
        .DAC_BITS    (DAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_load_index  (i_s_tdata[IDX_W-1:0]),
        .i_point_x     (i_s_tdata[IDX_W+COORD_W-1:IDX_W]),
        .i_point_y     (i_s_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W]),
        .i_point_blank (i_s_tdata[IDX_W+2*COORD_W]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata)
    );

`ifndef SYNTHESIS
    // a tick transfer closes the input until its result is formed
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_TICK)) |=> !o_s_tready)
        else $error("input accepted while a tick is in flight");

    // a result is loaded only into a free output slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("pending result overwritten");

    // a fresh division never reports done in the following cycle
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider done right after start");

    // a result appears only after the controller loaded it
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without a load");
`endif

endmodule

// ===== tb/vector_display_point_scanner_scoreboard.sv =====
`timescale 1ns / 100ps
// scoreboard of the vector display point scanner: tracks register writes and the point list,
// predicts each beam result from accepted ticks and compares the master-side transfers
// depends on vdps_pkg for widths, register indexes and operation codes
module vector_display_point_scanner_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // tdata: load_index[9:0], point_x[17:10], point_y[25:18], point_blank[26], zero above
    input  logic [vdps_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: operation
    input  logic                          i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: blank_level[0], x_dac_word[13:1], y_dac_word[29:14], clamped[30], zero[31]
    input  logic [vdps_pkg::M_DATA_W-1:0] i_m_tdata,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [vdps_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [vdps_pkg::PDATA_W-1:0]  i_pwdata,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_checked
);
    import vdps_pkg::*;

    localparam int DEPTH    = DEF_POINT_DEPTH;
    localparam int DAC_TOP  = (1 << DEF_DAC_BITS) - 1;

    typedef struct packed {
        logic               blank_level;
        logic [XWORD_W-1:0] x_dac_word;
        logic [YWORD_W-1:0] y_dac_word;
        logic               clamped;
    } t_beam_sample;

    // mirrored registers and point list
    t_cfg               regs;
    logic [COORD_W-1:0] x_mem     [0:DEPTH-1];
    logic [COORD_W-1:0] y_mem     [0:DEPTH-1];
    logic               blank_mem [0:DEPTH-1];
    logic [IDX_W-1:0]   scan_idx;

    t_beam_sample       beams_due [$];
    t_beam_sample       want;
    logic [SCALE_W:0]   x_fit, y_fit;
    logic [IDX_W-1:0]   at;
    int                 nxt;

    // signed span scaling with truncating division, zero divisor taken as one
    function automatic int span_scale(input logic [COORD_W-1:0] v, input logic [OFS_W-1:0] lo,
                                      input logic [OFS_W-1:0] hi, input logic [DIV_W-1:0] dv);
        int diff;
        int d;
        diff = int'(hi) - int'(lo);
        d    = (dv == '0) ? 1 : int'(dv);
        return int'(lo) + (int'(v) * diff) / d;
    endfunction

    // saturate into the dac range, top bit flags a clamp
    function automatic logic [SCALE_W:0] fit_dac(input int r);
        if (r < 0)
            return {1'b1, {SCALE_W{1'b0}}};
        if (r > DAC_TOP)
            return {1'b1, SCALE_W'(DAC_TOP)};
        return {1'b0, SCALE_W'(r)};
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.x_offset_min = '0;
            regs.x_span_max   = 12'd4095;
            regs.x_divisor    = 9'd255;
            regs.y_offset_min = '0;
            regs.y_span_max   = 12'd4095;
            regs.y_divisor    = 9'd255;
            regs.point_count  = 11'd1;
            scan_idx          = '0;
            beams_due.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_X_OFFSET_MIN: regs.x_offset_min = i_pwdata[OFS_W-1:0];
                    REG_X_SPAN_MAX:   regs.x_span_max   = i_pwdata[OFS_W-1:0];
                    REG_X_DIVISOR:    regs.x_divisor    = i_pwdata[DIV_W-1:0];
                    REG_Y_OFFSET_MIN: regs.y_offset_min = i_pwdata[OFS_W-1:0];
                    REG_Y_SPAN_MAX:   regs.y_span_max   = i_pwdata[OFS_W-1:0];
                    REG_Y_DIVISOR:    regs.y_divisor    = i_pwdata[DIV_W-1:0];
                    REG_POINT_COUNT:  regs.point_count  = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // input transfer: store a point or predict the beam result
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_LOAD) begin
                    at            = i_s_tdata[IDX_W-1:0];
                    x_mem[at]     = i_s_tdata[17:10];
                    y_mem[at]     = i_s_tdata[25:18];
                    blank_mem[at] = i_s_tdata[26];
                end else begin
                    at    = scan_idx;
                    x_fit = fit_dac(span_scale(x_mem[at], regs.x_offset_min,
                                               regs.x_span_max, regs.x_divisor));
                    y_fit = fit_dac(span_scale(y_mem[at], regs.y_offset_min,
                                               regs.y_span_max, regs.y_divisor));
                    want.blank_level = ~blank_mem[at];
                    want.x_dac_word  = {X_HDR, x_fit[SCALE_W-1:0]};
                    want.y_dac_word  = {Y_HDR, y_fit[SCALE_W-1:0]};
                    want.clamped     = x_fit[SCALE_W] | y_fit[SCALE_W];
                    beams_due.push_back(want);
                    // wrap at point_count or at the list depth
                    nxt = int'(at) + 1;
                    if (nxt >= int'(regs.point_count) || nxt >= DEPTH)
                        nxt = 0;
                    scan_idx = IDX_W'(nxt);
                end
            end

            // output transfer against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (beams_due.size() == 0) begin
                    $error("beam result 0x%0h with nothing expected", i_m_tdata);
                    o_mismatches++;
                end else begin
                    want = beams_due.pop_front();
                    check_field("blank_level", 32'(want.blank_level), 32'(i_m_tdata[0]));
                    check_field("x_dac_word", 32'(want.x_dac_word), 32'(i_m_tdata[13:1]));
                    check_field("y_dac_word", 32'(want.y_dac_word), 32'(i_m_tdata[29:14]));
                    check_field("clamped", 32'(want.clamped), 32'(i_m_tdata[30]));
                    o_checked++;
                end
            end
        end
        o_outstanding = beams_due.size();
    end

endmodule

// ===== tb/vector_display_point_scanner_test.sv =====
`timescale 1ns / 100ps
// testbench top of the vector display point scanner: clock, reset, stimulus and verdict
// depends on vdps_pkg, the block and vector_display_point_scanner_scoreboard
module vector_display_point_scanner_test;
    import vdps_pkg::*;

    localparam int DEPTH       = DEF_POINT_DEPTH;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;   // beyond the tick latency of the block

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                i_s_tuser  = OP_LOAD;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int beam_errors;
    int beams_open;
    int beams_checked;

    // stimulus state
    int               gap_pct   = 0;
    int               stall_pct = 0;
    bit               hold_req  = 1'b0;
    int               hold_left = 0;
    bit               written [0:DEPTH-1];
    logic [IDX_W-1:0] scan_pos  = '0;
    logic [CNT_W-1:0] cur_count = 11'd1;
    int               n_loads   = 0;
    int               n_ticks   = 0;
    int               n_settings = 0;

    vector_display_point_scanner u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    vector_display_point_scanner_scoreboard u_score (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (beam_errors),
        .o_outstanding (beams_open),
        .o_checked     (beams_checked)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("vector_display_point_scanner_test: done, errors");
        $finish;
    end

    // result side: random stalls, or a long hold-off counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 7; stall_pct = 7; end
        endcase
    endtask

    // one input transfer, with random gaps ahead of it
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic pb);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'b0, pb, py, px, idx};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic load_point(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic pb);
        send_item(OP_LOAD, idx, px, py, pb);
        written[idx] = 1'b1;
        n_loads++;
    endtask

    task automatic load_random(input logic [IDX_W-1:0] idx);
        load_point(idx, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                   1'($urandom_range(1)));
    endtask

    // a tick never reads an entry that was not loaded before
    task automatic tick_point();
        logic [CNT_W-1:0] nxt;
        if (!written[scan_pos])
            load_random(scan_pos);
        send_item(OP_TICK, IDX_W'($urandom_range(DEPTH - 1)), COORD_W'($urandom_range(255)),
                  COORD_W'($urandom_range(255)), 1'($urandom_range(1)));
        n_ticks++;
        nxt = CNT_W'(scan_pos) + 11'd1;
        if (nxt >= cur_count || nxt >= DEPTH)
            nxt = '0;
        scan_pos = nxt[IDX_W-1:0];
    endtask

    // wait until every beam result is back, then let the block settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (beams_open != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // setup and access cycle; the caller closes the last transfer
    task automatic write_reg(input logic [2:0] reg_idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
    endtask

    task automatic apply_settings(input int xmin, input int xmax, input int xdiv,
                                  input int ymin, input int ymax, input int ydiv,
                                  input int pcount);
        drain();
        write_reg(REG_X_OFFSET_MIN, xmin);
        write_reg(REG_X_SPAN_MAX, xmax);
        write_reg(REG_X_DIVISOR, xdiv);
        write_reg(REG_Y_OFFSET_MIN, ymin);
        write_reg(REG_Y_SPAN_MAX, ymax);
        write_reg(REG_Y_DIVISOR, ydiv);
        write_reg(REG_POINT_COUNT, pcount);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_count = CNT_W'(pcount);
        n_settings++;
    endtask

    // mostly short lists, now and then a long one or an odd count
    task automatic random_settings(input int pcount);
        apply_settings($urandom_range(4095), $urandom_range(4095), $urandom_range(511),
                       $urandom_range(4095), $urandom_range(4095), $urandom_range(511),
                       pcount);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, list of one point, both coordinate extremes
        set_idling(0);
        load_point(10'd0, 8'd0, 8'd0, 1'b0);
        tick_point();
        load_point(10'd0, 8'd255, 8'd255, 1'b1);
        tick_point();
        load_point(10'd1023, 8'h55, 8'hAA, 1'b0);
        load_point(10'd1, 8'hAA, 8'h55, 1'b0);
        load_point(10'd2, 8'd128, 8'd1, 1'b1);

        // zero divisor clamps high, divisor above 256, inverted y span, count of zero
        apply_settings(0, 4095, 0, 4095, 0, 511, 0);
        tick_point();
        tick_point();
        // x falls below zero, flat y span, odd count of three
        apply_settings(10, 0, 1, 4095, 4095, 256, 3);
        repeat (4) tick_point();
        // inverted x span, y clamps high through a divisor of one
        apply_settings(4095, 0, 256, 0, 4095, 1, 2);
        repeat (2) tick_point();

        // long result hold-off while ticks keep coming, input must back up
        apply_settings(0, 4095, 255, 0, 4095, 255, 4);
        hold_req = 1'b1;
        repeat (8) tick_point();

        // random phases over all idling modes
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 5)
                random_settings(1024);
            else if ($urandom_range(3) == 0)
                random_settings($urandom_range(2047));
            else
                random_settings($urandom_range(1, 12));
            set_idling(ph % 4);
            repeat (45) begin
                if ($urandom_range(99) < 35)
                    load_random(IDX_W'($urandom_range(DEPTH - 1)));
                else
                    tick_point();
            end
        end

        drain();
        $display("stimulus: %0d loads, %0d ticks under %0d register settings",
                 n_loads, n_ticks, n_settings);
        $display("beam results compared: %0d, mismatches: %0d", beams_checked, beam_errors);
        if (beam_errors == 0)
            $display("vector_display_point_scanner_test: done, clean");
        else
            $display("vector_display_point_scanner_test: done, errors");
        $finish;
    end

endmodule
